@@ hdl/life_grid_generation_engine_defines.svh @@
// Assertion macros used by the checker file of the life grid engine.
`ifndef LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lge_checker: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define LGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lge_checker: next-cycle property violated");

`endif

@@ hdl/lge_pkg.sv @@
package lge_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_W     = 6;
  localparam int GEN_W       = 32;

  // Slave tdata layout: playing, col_x, row_y from bit 0 up.
  localparam int IN_TDATA_W  = 16;
  localparam int IN_PLAY_BIT = 0;
  localparam int IN_COL_LSB  = 1;
  localparam int IN_ROW_LSB  = 7;

  // Master tdata layout: cell_value, advanced, generation_count, out_of_range.
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_USED_W   = 35;
  localparam int OUT_CELL_BIT = 0;
  localparam int OUT_ADV_BIT  = 1;
  localparam int OUT_GEN_LSB  = 2;
  localparam int OUT_OOR_BIT  = 34;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_COLS_RST  = 7'd64;
  localparam logic [CFG_W-1:0]     CFG_ROWS_RST  = 7'd64;

  // Neighbor counts of rule B3/S23.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    KIND_STEP   = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_STEP_RD,
    S_STEP_PRIME,
    S_STEP_ROW,
    S_CELL_RD,
    S_CELL,
    S_CLEAR,
    S_RESP
  } state_e;

endpackage

@@ hdl/life_grid_generation_engine.sv @@
// Channel   | Direction | Handshake                  | Payload
// s_axis    | in        | s_axis_tvalid/tready       | tuser kind, tdata playing/col_x/row_y
// m_axis    | out       | m_axis_tvalid/tready       | tdata cell/advanced/generation/oor
// cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A playing step passes S_STEP_RD, S_STEP_PRIME and S_STEP_ROW: the grid memory
// delivers and takes back one row per cycle. Toggle and read pass S_CELL_RD and S_CELL,
// clear passes S_CLEAR; a step without playing and an out-of-range request go to S_RESP.
// After reset a clearing pass writes all MAX_ROWS rows, one a cycle, with
// s_axis_tready low. The next item is taken while a result waits in the
// output register; its own result then stalls until that register frees up.
module life_grid_generation_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: playing[0], col_x[6:1], row_y[12:7], zero fill [15:13].
  input  logic [lge_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: kind[1:0].
  input  logic [1:0]                          s_axis_tuser,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: cell_value[0], advanced[1], generation_count[33:2],
  // out_of_range[34], zero fill [39:35].
  output logic [lge_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lge_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lge_pkg::CFG_W-1:0]           cfg_data_i
);
  import lge_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  state_e               state_q, state_d;
  logic [RW-1:0]        row_q;
  kind_e                kind_q;
  logic [COORD_W-1:0]   col_q, rowsel_q;
  logic [MAX_COLS-1:0]  above_q, cur_q, rd_q;
  logic                 res_cell_q, res_adv_q, res_oor_q;
  logic [GEN_W-1:0]     gen_q;
  logic [CFG_W-1:0]     grid_cols_q, grid_rows_q;
  logic                 m_valid_q;
  logic                 out_cell_q, out_adv_q, out_oor_q;
  logic [GEN_W-1:0]     out_gen_q;

  logic                 in_acc;
  kind_e                in_kind;
  logic                 in_playing, in_oor;
  logic [COORD_W-1:0]   in_col, in_row;
  logic [CCW-1:0]       cols;
  logic [RCW-1:0]       rows;
  logic [MAX_COLS-1:0]  colmask, below, new_row;
  logic [RCW-1:0]       row_nxt;
  logic                 last_row, load_out;
  logic                 rd_en, wr_en;
  logic [RW-1:0]        rd_addr, wr_addr;
  logic [MAX_COLS-1:0]  wr_data;

  // Live grid, one row of cells per word.
  logic [MAX_COLS-1:0]  grid_mem [MAX_ROWS];

  // B3/S23 for one cell from its 3x3 neighborhood.
  function automatic logic life_cell(logic [2:0] up, logic [2:0] mid, logic [2:0] dn);
    logic [3:0] cnt;
    cnt = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
        + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
    return (cnt == BIRTH_COUNT) || (mid[1] && (cnt == SURVIVE_COUNT));
  endfunction

  // Input field unpacking.
  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign in_kind    = kind_e'(s_axis_tuser);
  assign in_playing = s_axis_tdata[IN_PLAY_BIT];
  assign in_col     = s_axis_tdata[IN_COL_LSB +: COORD_W];
  assign in_row     = s_axis_tdata[IN_ROW_LSB +: COORD_W];

  // Size in use, saturated to 1..MAX.
  always_comb begin
    if (grid_cols_q == '0) begin
      cols = CCW'(1);
    end else if (int'(grid_cols_q) > MAX_COLS) begin
      cols = CCW'(MAX_COLS);
    end else begin
      cols = CCW'(grid_cols_q);
    end
    if (grid_rows_q == '0) begin
      rows = RCW'(1);
    end else if (int'(grid_rows_q) > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(grid_rows_q);
    end
  end

  assign in_oor = (int'(in_col) >= int'(cols)) || (int'(in_row) >= int'(rows));

  // Columns in use; the rest count as dead and keep their value.
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      colmask[x] = (x < int'(cols));
    end
  end

  // New row from the old rows above, at and below the current one.
  assign row_nxt  = RCW'(row_q) + RCW'(1);
  assign last_row = (row_nxt == rows);
  assign below    = (row_nxt < rows) ? rd_q : '0;

  always_comb begin
    logic [MAX_COLS+1:0] pa, pc, pb;
    pa = {1'b0, above_q & colmask, 1'b0};
    pc = {1'b0, cur_q & colmask, 1'b0};
    pb = {1'b0, below & colmask, 1'b0};
    for (int x = 0; x < MAX_COLS; x++) begin
      new_row[x] = colmask[x] ? life_cell(pa[x +: 3], pc[x +: 3], pb[x +: 3]) : cur_q[x];
    end
  end

  assign load_out = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (row_q == RW'(MAX_ROWS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_STEP:             state_d = in_playing ? S_STEP_RD : S_RESP;
            KIND_CLEAR:            state_d = S_CLEAR;
            KIND_TOGGLE, KIND_READ: state_d = in_oor ? S_RESP : S_CELL_RD;
            default:               state_d = S_RESP;
          endcase
        end
      end
      S_STEP_RD:    state_d = S_STEP_PRIME;
      S_STEP_PRIME: state_d = S_STEP_ROW;
      S_STEP_ROW: begin
        if (last_row) state_d = S_RESP;
      end
      S_CELL_RD:    state_d = S_CELL;
      S_CELL:       state_d = S_RESP;
      S_CLEAR: begin
        if (row_q == RW'(MAX_ROWS - 1)) state_d = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_d = S_IDLE;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // Memory port control per state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = '0;
    case (state_q)
      S_INIT, S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_STEP_RD: begin
        rd_en = 1'b1;
      end
      S_STEP_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = RW'(1);
      end
      S_STEP_ROW: begin
        rd_en   = (int'(row_q) + 2) < MAX_ROWS;
        rd_addr = row_q + RW'(2);
        wr_en   = 1'b1;
        wr_data = new_row;
      end
      S_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = RW'(rowsel_q);
      end
      S_CELL: begin
        wr_en   = (kind_q == KIND_TOGGLE);
        wr_addr = RW'(rowsel_q);
        wr_data = rd_q;
        wr_data[CW'(col_q)] = ~rd_q[CW'(col_q)];
      end
      default: begin
      end
    endcase
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= grid_mem[rd_addr];
  end

  // Control state, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      gen_q       <= '0;
      grid_cols_q <= CFG_COLS_RST;
      grid_rows_q <= CFG_ROWS_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_INIT, S_CLEAR, S_STEP_ROW: row_q <= row_q + RW'(1);
        S_IDLE:                      row_q <= '0;
        default: begin
        end
      endcase
      if (state_q == S_STEP_ROW && last_row) gen_q <= gen_q + GEN_W'(1);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
          CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Item context, row window and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q     <= in_kind;
      col_q      <= in_col;
      rowsel_q   <= in_row;
      res_cell_q <= 1'b0;
      res_adv_q  <= (in_kind == KIND_STEP) && in_playing;
      res_oor_q  <= ((in_kind == KIND_TOGGLE) || (in_kind == KIND_READ)) && in_oor;
    end
    case (state_q)
      S_STEP_PRIME: begin
        above_q <= '0;
        cur_q   <= rd_q;
      end
      S_STEP_ROW: begin
        above_q <= cur_q;
        cur_q   <= rd_q;
      end
      S_CELL: begin
        res_cell_q <= rd_q[CW'(col_q)] ^ (kind_q == KIND_TOGGLE);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_cell_q <= res_cell_q;
      out_adv_q  <= res_adv_q;
      out_oor_q  <= res_oor_q;
      out_gen_q  <= gen_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                          out_oor_q, out_gen_q, out_adv_q, out_cell_q};

endmodule

@@ hdl/lge_checker.sv @@
`include "life_grid_generation_engine_defines.svh"

module lge_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lge_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lge_pkg::*;

  logic [1:0]       outstanding_q;
  logic [GEN_W-1:0] last_gen_q;
  logic             in_txn, out_txn;
  logic [GEN_W-1:0] out_gen;
  logic             out_adv;

  assign in_txn  = s_axis_tvalid & s_axis_tready;
  assign out_txn = m_axis_tvalid & m_axis_tready;
  assign out_gen = m_axis_tdata[OUT_GEN_LSB +: GEN_W];
  assign out_adv = m_axis_tdata[OUT_ADV_BIT];

  // Items taken but not yet answered, and the last generation delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      last_gen_q    <= '0;
    end else begin
      if (in_txn && !out_txn && outstanding_q != 2'd3) begin
        outstanding_q <= outstanding_q + 2'd1;
      end else if (!in_txn && out_txn && outstanding_q != 2'd0) begin
        outstanding_q <= outstanding_q - 2'd1;
      end
      if (out_txn) last_gen_q <= out_gen;
    end
  end

  // A stalled result holds its payload.
  `LGE_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Items are worked one at a time: ready drops after each input transaction.
  `LGE_ASSERT_NEXT(a_one_at_a_time, in_txn, !s_axis_tready)
  // A result only answers a taken item, and at most two are in flight.
  `LGE_ASSERT_SAME(a_no_invented, m_axis_tvalid, outstanding_q != 2'd0 && outstanding_q != 2'd3)
  // The generation moves by one on an advanced result and stays otherwise.
  `LGE_ASSERT_SAME(a_gen_sequence, out_txn, out_gen == (last_gen_q + GEN_W'(out_adv)))

endmodule

bind life_grid_generation_engine lge_checker u_lge_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lge_pkg::*;

  localparam int MAX_COLS       = 64;
  localparam int MAX_ROWS       = 64;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = MAX_ROWS + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 20;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic             cell_val;
    logic             adv;
    logic [GEN_W-1:0] gen;
    logic             oor;
  } gen_result_t;

  // A directed row either sends one request or programs the grid size.
  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } row_op_e;

  typedef struct packed {
    row_op_e     op;
    kind_e       kind;
    logic        play;
    logic [6:0]  arg_x;
    logic [6:0]  arg_y;
    logic        typed;
    logic        e_cell;
    logic        e_adv;
    logic [31:0] e_gen;
    logic        e_oor;
  } directed_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  // Shadow copy of the grid, the counter and the size registers.
  logic [MAX_COLS-1:0] life_grid [MAX_ROWS];
  logic [GEN_W-1:0]    gen_count;
  logic [CFG_W-1:0]    size_cols;
  logic [CFG_W-1:0]    size_rows;

  gen_result_t pending_results [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          rx_hold = 0;
  bit          rx_stalls = 1'b1;
  bit          tx_gaps = 1'b1;

  // Directed requests: reset state, extremes, saturating sizes, resizing and clear.
  directed_row_t directed_rows [28] = '{
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd63,  7'd63,  1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd63,  7'd63,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_STEP,   1'b0, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd0,   7'd0,   1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd1,   7'd0,   1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd2,   7'd0,   1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_STEP,   1'b1, 7'd0,   7'd0,   1'b1, 1'b0, 1'b1, 32'd1, 1'b0},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd1,   7'd1,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_STEP,   1'b1, 7'd0,   7'd0,   1'b1, 1'b0, 1'b1, 32'd2, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd5,   7'd5,   1'b1, 1'b1, 1'b0, 32'd2, 1'b0},
    '{ROW_SIZE, KIND_STEP,   1'b0, 7'd0,   7'd127, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd1,   7'd0,   1'b1, 1'b0, 1'b0, 32'd2, 1'b1},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd0,   7'd63,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd63,  7'd0,   1'b1, 1'b0, 1'b0, 32'd2, 1'b1},
    '{ROW_ITEM, KIND_STEP,   1'b1, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_SIZE, KIND_STEP,   1'b0, 7'd64,  7'd64,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd5,   7'd5,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_CLEAR,  1'b0, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 32'd3, 1'b0},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd5,   7'd5,   1'b1, 1'b0, 1'b0, 32'd3, 1'b0},
    '{ROW_SIZE, KIND_STEP,   1'b0, 7'd127, 7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd63,  7'd0,   1'b1, 1'b1, 1'b0, 32'd3, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd0,   7'd1,   1'b1, 1'b0, 1'b0, 32'd3, 1'b1},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd62,  7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_TOGGLE, 1'b0, 7'd61,  7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_STEP,   1'b1, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_READ,   1'b0, 7'd62,  7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM, KIND_STEP,   1'b0, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0}
  };

  life_grid_generation_engine #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock with an 8 ns period.
  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // A size register outside 1..limit saturates into that range.
  function automatic int used_size(logic [CFG_W-1:0] size_reg, int limit);
    if (size_reg < 1) return 1;
    if (size_reg > limit) return limit;
    return int'(size_reg);
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one request to the shadow state and returns the result it produces.
  function automatic gen_result_t next_life_result(kind_e kind, logic play,
                                                   logic [COORD_W-1:0] cx,
                                                   logic [COORD_W-1:0] ry);
    gen_result_t         res;
    logic [MAX_COLS-1:0] snap [MAX_ROWS];
    int                  cols;
    int                  rows;
    int                  n;
    int                  nx;
    int                  ny;
    res  = '0;
    cols = used_size(size_cols, MAX_COLS);
    rows = used_size(size_rows, MAX_ROWS);
    case (kind)
      KIND_STEP: begin
        // Every cell is computed from the copy taken before the step.
        snap = life_grid;
        if (play) begin
          for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
              n = 0;
              for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                  nx = x + dx;
                  ny = y + dy;
                  if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < cols && ny < rows)
                    n += snap[ny][nx];
                end
              end
              if (snap[y][x])
                life_grid[y][x] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
              else
                life_grid[y][x] = (n == BIRTH_COUNT);
            end
          end
          gen_count++;
          res.adv = 1'b1;
        end
      end
      KIND_CLEAR: begin
        foreach (life_grid[y]) life_grid[y] = '0;
      end
      default: begin
        if (cx >= cols || ry >= rows) begin
          res.oor = 1'b1;
        end else if (kind == KIND_TOGGLE) begin
          life_grid[ry][cx] = ~life_grid[ry][cx];
          res.cell_val = life_grid[ry][cx];
        end else begin
          res.cell_val = life_grid[ry][cx];
        end
      end
    endcase
    res.gen = gen_count;
    return res;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Sends one request, records its expected result and then pauses at random.
  task automatic send_request(kind_e kind, logic play, logic [COORD_W-1:0] cx,
                              logic [COORD_W-1:0] ry, logic typed, gen_result_t typed_res);
    logic [IN_TDATA_W-1:0] word;
    gen_result_t           predicted;
    int                    gap;
    word                               = '0;
    word[IN_PLAY_BIT]                  = play;
    word[IN_COL_LSB +: COORD_W]        = cx;
    word[IN_ROW_LSB +: COORD_W]        = ry;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_life_result(kind, play, cx, ry);
    pending_results.push_back(typed ? typed_res : predicted);
    gap = (tx_gaps && $urandom_range(0, 1) == 1) ? idle_length() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both size registers back to back while the engine is idle.
  task automatic program_size(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GRID_COLS;
    cfg_data_i  <= cols;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_cols = cols;
    cfg_index_i <= CFG_GRID_ROWS;
    cfg_data_i  <= rows;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_rows = rows;
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver stalls at random while stalls are enabled.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      rx_hold = idle_length();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    gen_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation waiting, got tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_value", want.cell_val, m_axis_tdata[OUT_CELL_BIT]);
        check_field("advanced", want.adv, m_axis_tdata[OUT_ADV_BIT]);
        check_field("generation_count", want.gen, m_axis_tdata[OUT_GEN_LSB +: GEN_W]);
        check_field("out_of_range", want.oor, m_axis_tdata[OUT_OOR_BIT]);
        check_field("zero fill", '0, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W]);
      end
    end
  end

  // Ends the run when no transaction of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0]   phase_cols [RANDOM_PHASES];
    logic [CFG_W-1:0]   phase_rows [RANDOM_PHASES];
    logic [CFG_W-1:0]   cols_val;
    logic [CFG_W-1:0]   rows_val;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] ry;
    logic               play;
    kind_e              kind;
    int                 pick;
    int                 uc;
    int                 ur;
    directed_row_t      row;

    phase_cols = '{7'd8, 7'd3, 7'd64, 7'd12, 7'd127, 7'd0};
    phase_rows = '{7'd8, 7'd3, 7'd6, 7'd64, 7'd9, 7'd0};

    // All inputs start at known values; the shadow state matches reset.
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_STEP;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_GRID_COLS;
    cfg_data_i    = '0;
    foreach (life_grid[y]) life_grid[y] = '0;
    gen_count = '0;
    size_cols = CFG_COLS_RST;
    size_rows = CFG_ROWS_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_SIZE)
        program_size(row.arg_x, row.arg_y);
      else
        send_request(row.kind, row.play, row.arg_x[COORD_W-1:0], row.arg_y[COORD_W-1:0],
                     row.typed, '{row.e_cell, row.e_adv, row.e_gen, row.e_oor});
    end

    // Random part: several grid sizes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cols_val = (p == RANDOM_PHASES - 1) ? CFG_W'($urandom_range(1, 64)) : phase_cols[p];
      rows_val = (p == RANDOM_PHASES - 1) ? CFG_W'($urandom_range(1, 64)) : phase_rows[p];
      program_size(cols_val, rows_val);
      tx_gaps   = (p != 0);
      rx_stalls = (p != 0);
      uc = used_size(size_cols, MAX_COLS);
      ur = used_size(size_rows, MAX_ROWS);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        play = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 85) begin
          cx = $urandom_range(0, uc - 1);
          ry = $urandom_range(0, ur - 1);
        end else begin
          cx = $urandom_range(0, 63);
          ry = $urandom_range(0, 63);
        end
        if (pick < 40)
          kind = KIND_TOGGLE;
        else if (pick < 65)
          kind = KIND_STEP;
        else if (pick < 90)
          kind = KIND_READ;
        else if (pick < 95)
          kind = KIND_CLEAR;
        else
          kind = kind_e'($urandom_range(0, 3));
        send_request(kind, play, cx, ry, 1'b0, '0);
        if ($urandom_range(0, 99) < 4) drain_results();
      end
    end

    // Let every outstanding result arrive, then allow the pipeline to settle.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ life_grid_generation_engine.f @@
+incdir+hdl
hdl/lge_pkg.sv
hdl/life_grid_generation_engine.sv
hdl/lge_checker.sv
tb/sv/testbench.sv
